@@ rtl/core/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// pic_pkg
// Types and constants shared by the priority interrupt controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

    localparam int FUNC_W   = 3;
    localparam int SRC_W    = 3;
    localparam int ACK_W    = 8;
    localparam int ADDR_W   = 16;
    localparam int MULT_W   = 8;
    localparam int CNT_W    = 4;
    localparam int CAUSE_W  = 8;
    localparam int PROD_W   = SRC_W + MULT_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REQUEST    = 3'd0,
        FUNC_CLEAR      = 3'd1,
        FUNC_SET_ENABLE = 3'd2,
        FUNC_READ_CAUSE = 3'd3,
        FUNC_WRITE_ACK  = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAUSE_ADDRESS = 2'd0,
        REG_CAUSE_MASK    = 2'd1,
        REG_CAUSE_MULT    = 2'd2,
        REG_SOURCE_COUNT  = 2'd3
    } t_cfg_reg;

    localparam logic [ADDR_W-1:0] RST_CAUSE_ADDRESS = 16'h0000;
    localparam logic [ADDR_W-1:0] RST_CAUSE_MASK    = 16'hFFFF;
    localparam logic [MULT_W-1:0] RST_CAUSE_MULT    = 8'd1;
    localparam logic [CNT_W-1:0]  RST_SOURCE_COUNT  = 4'd8;

endpackage

`default_nettype wire

@@ rtl/core/priority_interrupt_controller_top.sv @@
// ----------------------------------------------------------------------------
// priority_interrupt_controller_top
// Fixed-priority interrupt controller with pending and enable bits per source.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one operation per
//   transfer: request, clear, set enable, read cause or write acknowledge.
//   Output channel (o_out_valid / i_out_stall) returns one result for every
//   operation: cause value, any-pending flag and masked address match, all
//   reflecting the state after that operation.
//   The operation lands in an input register; the state update, priority
//   encode and cause multiply then run on it and land in the result
//   register. Throughput is one operation per cycle while the output
//   channel is not stalled.
//   When the receiver stalls, the result register holds; one further
//   operation is taken into the input register, then o_in_stall rises.
//   Reset clears pending bits, sets all enable bits and loads the register
//   defaults (address 0, mask all ones, multiplier 1, source count 8).
//   Configuration writes (i_cfg_we) take effect at once; write only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_interrupt_controller_top
    import pic_pkg::*;
#(
    parameter int MAX_SOURCES = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [SRC_W-1:0]      i_source,
    input  wire logic                  i_enable_flag,
    input  wire logic [ACK_W-1:0]      i_ack_mask,
    input  wire logic [ADDR_W-1:0]     i_bus_address,

    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      logic [CAUSE_W-1:0]    o_cause_value,
    output      logic                  o_any_pending,
    output      logic                  o_address_match
);

    // configuration
    logic [ADDR_W-1:0] r_cause_address;
    logic [ADDR_W-1:0] r_cause_mask;
    logic [MULT_W-1:0] r_cause_mult;
    logic [CNT_W-1:0]  r_source_count;

    // state
    logic [MAX_SOURCES-1:0] r_pending, n_pending;
    logic [MAX_SOURCES-1:0] r_enable,  n_enable;

    // input register
    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [SRC_W-1:0]  r_source;
    logic              r_enable_flag;
    logic [ACK_W-1:0]  r_ack_mask;
    logic [ADDR_W-1:0] r_bus_address;

    // result register
    logic               r_out_valid;
    logic [CAUSE_W-1:0] r_cause_value, n_cause_value;
    logic               r_any_pending, n_any_pending;
    logic               r_address_match, n_address_match;

    logic                   advance;
    logic                   in_take;
    logic [MAX_SOURCES-1:0] src_sel;
    logic [MAX_SOURCES-1:0] in_range;
    logic [MAX_SOURCES-1:0] active;
    logic [SRC_W-1:0]       winner;
    logic [PROD_W-1:0]      product;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        for (int i = 0; i < MAX_SOURCES; i++) begin
            src_sel[i]  = (r_source == SRC_W'(i));
            // sources at or above the count (clamped to the maximum) are out of use
            in_range[i] = (r_source_count > CNT_W'(i));
        end
    end

    always_comb begin
        n_pending = r_pending;
        n_enable  = r_enable;
        case (t_func'(r_func))
            FUNC_REQUEST:    n_pending = r_pending | (src_sel & in_range);
            FUNC_CLEAR:      n_pending = r_pending & ~(src_sel & in_range);
            FUNC_SET_ENABLE: begin
                if (r_enable_flag) begin
                    n_enable = r_enable | src_sel;
                end else begin
                    n_enable = r_enable & ~src_sel;
                end
            end
            FUNC_READ_CAUSE: n_pending = r_pending;
            FUNC_WRITE_ACK:  n_pending = r_pending & ~(r_ack_mask[MAX_SOURCES-1:0] & in_range);
            default:         n_pending = r_pending;
        endcase
    end

    // highest-numbered active source wins
    always_comb begin
        active = n_pending & n_enable & in_range;
        winner = '0;
        for (int i = 0; i < MAX_SOURCES; i++) begin
            if (active[i]) begin
                winner = SRC_W'(i);
            end
        end
        product         = PROD_W'(winner) * PROD_W'(r_cause_mult);
        n_any_pending   = |active;
        n_cause_value   = n_any_pending ? product[CAUSE_W-1:0] : '0;
        n_address_match = ((r_bus_address & r_cause_mask) ==
                           (r_cause_address & r_cause_mask));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cause_address <= RST_CAUSE_ADDRESS;
            r_cause_mask    <= RST_CAUSE_MASK;
            r_cause_mult    <= RST_CAUSE_MULT;
            r_source_count  <= RST_SOURCE_COUNT;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CAUSE_ADDRESS: r_cause_address <= i_cfg_data[ADDR_W-1:0];
                REG_CAUSE_MASK:    r_cause_mask    <= i_cfg_data[ADDR_W-1:0];
                REG_CAUSE_MULT:    r_cause_mult    <= i_cfg_data[MULT_W-1:0];
                REG_SOURCE_COUNT:  r_source_count  <= i_cfg_data[CNT_W-1:0];
                default:           r_source_count  <= r_source_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= '0;
            r_enable    <= '1;
        end else begin
            if (advance) begin
                r_in_valid  <= in_take;
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_pending <= n_pending;
                    r_enable  <= n_enable;
                end
            end else if (in_take) begin
                // output held: the empty input register still takes one transfer
                r_in_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func        <= i_func;
            r_source      <= i_source;
            r_enable_flag <= i_enable_flag;
            r_ack_mask    <= i_ack_mask;
            r_bus_address <= i_bus_address;
        end
        if (advance && r_in_valid) begin
            r_cause_value   <= n_cause_value;
            r_any_pending   <= n_any_pending;
            r_address_match <= n_address_match;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cause_value   = r_cause_value;
    assign o_any_pending   = r_any_pending;
    assign o_address_match = r_address_match;

`ifndef SYNTHESIS
    a_no_winner_zero_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_any_pending) |-> (o_cause_value == '0))
        else $error("cause value non-zero with nothing pending");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && i_out_stall) |=> r_in_valid)
        else $error("queued operation lost while output stalled");

    a_state_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_valid && advance) |=> ($stable(r_pending) && $stable(r_enable)))
        else $error("interrupt state changed without an operation");
`endif

endmodule

`default_nettype wire
